// ===== src/hamming_radius_adjacency_top_defines.svh =====
// ----------------------------------------------------------------------------
// Hamming radius adjacency: assertion macros
// Immediate-implication and next-cycle checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef HAMMING_RADIUS_ADJACENCY_TOP_DEFINES_SVH
`define HAMMING_RADIUS_ADJACENCY_TOP_DEFINES_SVH

`ifndef SYNTH

`define HRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HRA_ASSERT_IMP(label, ante, cons, msg)

`define HRA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/hra_pkg.sv =====
// ----------------------------------------------------------------------------
// Hamming radius adjacency: package
// Widths, reset values and register indexes shared by the block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package hra_pkg;

    localparam int unsigned INDEX_BITS_DEF = 16;
    localparam int unsigned MAX_DIGITS_DEF = 16;

    localparam int unsigned CFG_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIST_W    = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'((1 << DIST_W) - 1);

    localparam logic [CFG_W-1:0] RADIX_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] RADIX_RST   = CFG_W'(2);
    localparam logic [CFG_W-1:0] DIGITS_RST  = CFG_W'(1);
    localparam logic [CFG_W-1:0] RADIUS_RST  = CFG_W'(1);

    localparam int unsigned RADIX_CODES = 1 << CFG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX       = 2'd0,
        CFG_DIGIT_COUNT = 2'd1,
        CFG_RADIUS      = 2'd2
    } cfg_reg_t;

endpackage

// ===== src/hra_if.sv =====
// ----------------------------------------------------------------------------
// Hamming radius adjacency: channel interfaces
// Vertex pair request channel and adjacency result channel, valid/ready.
// ----------------------------------------------------------------------------
interface hra_pair_if #(
    parameter int unsigned INDEX_BITS = hra_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] first_vertex;
    logic [INDEX_BITS-1:0] second_vertex;

    modport source (output valid, output first_vertex, output second_vertex, input ready);
    modport sink   (input valid, input first_vertex, input second_vertex, output ready);
endinterface

interface hra_result_if;
    import hra_pkg::*;

    logic              valid;
    logic              ready;
    logic              adjacent;
    logic [DIST_W-1:0] distance;
    logic              out_of_range;

    modport source (output valid, output adjacent, output distance, output out_of_range,
                    input ready);
    modport sink   (input valid, input adjacent, input distance, input out_of_range,
                    output ready);
endinterface

// ===== src/hamming_radius_adjacency_top.sv =====
// ----------------------------------------------------------------------------
// Hamming radius adjacency: top level
// Digit-wise Hamming distance between two vertex indices, adjacency test.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : request channel, two vertex indices per request.
//   result : one result per request (adjacent, distance, out_of_range), in
//            request order.
//   cfg_*  : write port for radix, digit_count and radius; write only while
//            no request is in flight.
// Pipeline: an input register, the digit stages and the result register.
//   Each digit position takes three stages: multiply by the radix
//   reciprocal, multiply back, correct the remainder.
// Throughput: one request per cycle while result is taken every cycle.
// Stall: the whole pipeline holds while the result register is full and not
//   taken; pair.ready drops in the same cycle, nothing is lost or repeated.
// Reset: all stage valid bits clear, registers return to radix 2, one digit,
//   radius 1. The block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
`include "hamming_radius_adjacency_top_defines.svh"

module hamming_radius_adjacency_top #(
    parameter int unsigned INDEX_BITS = hra_pkg::INDEX_BITS_DEF,
    parameter int unsigned MAX_DIGITS = hra_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hra_pkg::CFG_W-1:0]     cfg_data,
    hra_pair_if.sink                      pair,
    hra_result_if.source                  result
);
    import hra_pkg::*;

    localparam int unsigned W     = INDEX_BITS;
    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned RW    = (W > CFG_W) ? W : CFG_W;
    localparam int unsigned RD    = (CNT_W > DIST_W) ? CNT_W : DIST_W;

    typedef struct packed {
        logic             valid;
        logic             neq;
        logic [CNT_W-1:0] diff_cnt;
        logic [W-1:0]     xa;
        logic [W-1:0]     xb;
    } carry_t;

    typedef struct packed {
        carry_t       c;
        logic [W-1:0] qa;
        logic [W-1:0] qb;
    } sta_t;

    typedef struct packed {
        carry_t       c;
        logic [W-1:0] qa;
        logic [W-1:0] qb;
        logic [W-1:0] qra;
        logic [W-1:0] qrb;
    } stb_t;

    logic [CFG_W-1:0] radix_reg;
    logic [CFG_W-1:0] digit_count_reg;
    logic [CFG_W-1:0] radius_reg;
    logic [CFG_W-1:0] eff_radix;
    logic [W-1:0]     recip_tab [RADIX_CODES];
    logic [W-1:0]     recip;
    logic             adv;

    carry_t c_reg  [MAX_DIGITS+1];
    carry_t c_next [MAX_DIGITS+1];
    sta_t   a_reg  [MAX_DIGITS];
    sta_t   a_next [MAX_DIGITS];
    stb_t   b_reg  [MAX_DIGITS];
    stb_t   b_next [MAX_DIGITS];

    logic [W-1:0] rem_fix_a [MAX_DIGITS];
    logic [W-1:0] rem_fix_b [MAX_DIGITS];

    logic              out_valid_reg;
    logic              adjacent_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              oor_reg;
    logic              adjacent_next;
    logic [DIST_W-1:0] distance_next;
    logic              oor_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RST;
            digit_count_reg <= DIGITS_RST;
            radius_reg      <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RADIX:       radix_reg       <= cfg_data;
                CFG_DIGIT_COUNT: digit_count_reg <= cfg_data;
                CFG_RADIUS:      radius_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign eff_radix = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;

    // reciprocal table: floor(2^W / r), low codes map to the minimum radix
    for (genvar r = 0; r < RADIX_CODES; r++)
    begin : g_recip
        localparam int unsigned DIVISOR = (r < 2) ? 2 : r;
        localparam logic [63:0] RV = (64'd1 << W) / DIVISOR;
        assign recip_tab[r] = RV[W-1:0];
    end

    assign recip = recip_tab[eff_radix];

    assign adv        = !out_valid_reg || result.ready;
    assign pair.ready = adv;

    // input stage
    always_comb
    begin
        c_next[0].valid    = pair.valid;
        c_next[0].neq      = (pair.first_vertex != pair.second_vertex);
        c_next[0].diff_cnt = '0;
        c_next[0].xa       = pair.first_vertex;
        c_next[0].xb       = pair.second_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0].valid <= 1'b0;
        end
        else if (adv)
        begin
            c_reg[0] <= c_next[0];
        end
    end

    // one digit position per three stages
    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_digit
        logic [2*W-1:0]     prod_a;
        logic [2*W-1:0]     prod_b;
        logic [W+CFG_W-1:0] qr_a;
        logic [W+CFG_W-1:0] qr_b;
        logic [W-1:0]       rem_a;
        logic [W-1:0]       rem_b;
        logic               fix_a;
        logic               fix_b;
        logic               active;

        assign active = (CFG_W'(g) < digit_count_reg);

        // estimate quotient: low by at most one
        always_comb
        begin
            prod_a       = (2*W)'(c_reg[g].xa) * (2*W)'(recip);
            prod_b       = (2*W)'(c_reg[g].xb) * (2*W)'(recip);
            a_next[g].c  = c_reg[g];
            a_next[g].qa = prod_a[2*W-1:W];
            a_next[g].qb = prod_b[2*W-1:W];
        end

        // multiply back by the radix
        always_comb
        begin
            qr_a          = (W+CFG_W)'(a_reg[g].qa) * (W+CFG_W)'(eff_radix);
            qr_b          = (W+CFG_W)'(a_reg[g].qb) * (W+CFG_W)'(eff_radix);
            b_next[g].c   = a_reg[g].c;
            b_next[g].qa  = a_reg[g].qa;
            b_next[g].qb  = a_reg[g].qb;
            b_next[g].qra = qr_a[W-1:0];
            b_next[g].qrb = qr_b[W-1:0];
        end

        // correct remainder, compare digits, advance quotient
        always_comb
        begin
            rem_a        = b_reg[g].c.xa - b_reg[g].qra;
            rem_b        = b_reg[g].c.xb - b_reg[g].qrb;
            fix_a        = (RW'(rem_a) >= RW'(eff_radix));
            fix_b        = (RW'(rem_b) >= RW'(eff_radix));
            rem_fix_a[g] = fix_a ? W'(RW'(rem_a) - RW'(eff_radix)) : rem_a;
            rem_fix_b[g] = fix_b ? W'(RW'(rem_b) - RW'(eff_radix)) : rem_b;
            c_next[g+1]  = b_reg[g].c;
            if (active)
            begin
                c_next[g+1].xa = b_reg[g].qa + W'(fix_a);
                c_next[g+1].xb = b_reg[g].qb + W'(fix_b);
                if (rem_fix_a[g] != rem_fix_b[g])
                begin
                    c_next[g+1].diff_cnt = b_reg[g].c.diff_cnt + CNT_W'(1);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_reg[g].c.valid <= 1'b0;
                b_reg[g].c.valid <= 1'b0;
                c_reg[g+1].valid <= 1'b0;
            end
            else if (adv)
            begin
                a_reg[g]   <= a_next[g];
                b_reg[g]   <= b_next[g];
                c_reg[g+1] <= c_next[g+1];
            end
        end
    end

    // result stage: leftover quotient flags an index beyond radix^digits
    always_comb
    begin
        oor_next = (c_reg[MAX_DIGITS].xa != '0) || (c_reg[MAX_DIGITS].xb != '0);
        if (RD'(c_reg[MAX_DIGITS].diff_cnt) > RD'(DIST_MAX))
        begin
            distance_next = DIST_MAX;
        end
        else
        begin
            distance_next = DIST_W'(c_reg[MAX_DIGITS].diff_cnt);
        end
        adjacent_next = !oor_next && c_reg[MAX_DIGITS].neq
                        && (RD'(distance_next) <= RD'(radius_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c_reg[MAX_DIGITS].valid;
            adjacent_reg  <= adjacent_next;
            distance_reg  <= distance_next;
            oor_reg       <= oor_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.adjacent     = adjacent_reg;
    assign result.distance     = distance_reg;
    assign result.out_of_range = oor_reg;

    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_chk
        `HRA_ASSERT_IMP(a_digit_below_radix, b_reg[g].c.valid,
            (RW'(rem_fix_a[g]) < RW'(eff_radix)) && (RW'(rem_fix_b[g]) < RW'(eff_radix)),
            "corrected digit not below radix")
    end

    `HRA_ASSERT_IMP(a_oor_not_adjacent, out_valid_reg, !(adjacent_reg && oor_reg),
        "out-of-range pair reported adjacent")

    `HRA_ASSERT_IMP(a_adjacent_within_radius, out_valid_reg && adjacent_reg,
        (distance_reg != '0) && (RD'(distance_reg) <= RD'(radius_reg)),
        "adjacent pair with zero distance or beyond radius")

    `HRA_ASSERT_IMP(a_distance_within_digits, out_valid_reg,
        RD'(distance_reg) <= RD'(digit_count_reg),
        "distance exceeds digit count")

    `HRA_ASSERT_NEXT(a_last_stage_delivers, c_reg[MAX_DIGITS].valid && adv,
        out_valid_reg, "last stage request lost before result register")

endmodule
